// File: hw/rtl/pp_pkg.sv
`default_nettype none
package pp_pkg;

  localparam int MaxLenDefault = 64;
  localparam int DataW         = 32;
  localparam int StepW         = 4;

  // Microprogram step addresses
  localparam logic [StepW-1:0] ST_IDLE   = 4'd0;
  localparam logic [StepW-1:0] ST_P_INIT = 4'd1;
  localparam logic [StepW-1:0] ST_P_RD   = 4'd2;
  localparam logic [StepW-1:0] ST_P_CMP  = 4'd3;
  localparam logic [StepW-1:0] ST_P_CHK  = 4'd4;
  localparam logic [StepW-1:0] ST_S_INIT = 4'd5;
  localparam logic [StepW-1:0] ST_S_ARD  = 4'd6;
  localparam logic [StepW-1:0] ST_S_PV   = 4'd7;
  localparam logic [StepW-1:0] ST_S_RD   = 4'd8;
  localparam logic [StepW-1:0] ST_S_CMP  = 4'd9;
  localparam logic [StepW-1:0] ST_E_INIT = 4'd10;
  localparam logic [StepW-1:0] ST_E_RD   = 4'd11;
  localparam logic [StepW-1:0] ST_E_OUT  = 4'd12;
  localparam logic [StepW-1:0] ST_E_DONE = 4'd13;

  // Read address select for port A
  localparam logic [1:0] ASEL_K     = 2'd0;
  localparam logic [1:0] ASEL_PIVOT = 2'd1;
  localparam logic [1:0] ASEL_MAP   = 2'd2;

  // Index counter operations
  localparam logic [2:0] KOP_HOLD = 3'd0;
  localparam logic [2:0] KOP_NM1  = 3'd1;
  localparam logic [2:0] KOP_DEC  = 3'd2;
  localparam logic [2:0] KOP_INC  = 3'd3;
  localparam logic [2:0] KOP_CLR  = 3'd4;

  // Handshake a step waits on before it advances
  localparam logic [1:0] WAIT_NONE = 2'd0;
  localparam logic [1:0] WAIT_IN   = 2'd1;
  localparam logic [1:0] WAIT_OUT  = 2'd2;

  // Branch condition select
  localparam logic [2:0] FLG_TRUE  = 3'd0;
  localparam logic [2:0] FLG_LAST  = 3'd1;
  localparam logic [2:0] FLG_N_ONE = 3'd2;
  localparam logic [2:0] FLG_LT_AB = 3'd3;
  localparam logic [2:0] FLG_K_ONE = 3'd4;
  localparam logic [2:0] FLG_LT_AP = 3'd5;
  localparam logic [2:0] FLG_K_END = 3'd6;

  typedef struct packed {
    logic             in_ready;
    logic             out_valid;
    logic             rd_a;
    logic             rd_b;
    logic [1:0]       asel;
    logic [2:0]       kop;
    logic             clr_found;
    logic             set_found;
    logic             ld_piv;
    logic             ld_pv;
    logic             ld_swp;
    logic             clr_seq;
    logic [1:0]       wait_on;
    logic [2:0]       flag;
    logic [StepW-1:0] tgt_t;
    logic [StepW-1:0] tgt_f;
  } ctrl_t;

  typedef struct packed {
    logic in_acc;
    logic out_acc;
    logic last;
    logic n_one;
    logic lt_ab;
    logic k_one;
    logic lt_ap;
    logic k_end;
  } stat_t;

  // Control store: one word per step
  function automatic ctrl_t ucode(input logic [StepW-1:0] step);
    ctrl_t c;
    c = '0;
    case (step)
      ST_IDLE: begin
        c.in_ready = 1'b1;
        c.wait_on  = WAIT_IN;
        c.flag     = FLG_LAST;
        c.tgt_t    = ST_P_INIT;
        c.tgt_f    = ST_IDLE;
      end
      ST_P_INIT: begin
        c.kop       = KOP_NM1;
        c.clr_found = 1'b1;
        c.flag      = FLG_N_ONE;
        c.tgt_t     = ST_E_INIT;
        c.tgt_f     = ST_P_RD;
      end
      ST_P_RD: begin
        c.asel  = ASEL_K;
        c.rd_a  = 1'b1;
        c.rd_b  = 1'b1;
        c.tgt_t = ST_P_CMP;
      end
      ST_P_CMP: begin
        c.ld_piv = 1'b1;
        c.flag   = FLG_LT_AB;
        c.tgt_t  = ST_S_INIT;
        c.tgt_f  = ST_P_CHK;
      end
      ST_P_CHK: begin
        c.kop   = KOP_DEC;
        c.flag  = FLG_K_ONE;
        c.tgt_t = ST_E_INIT;
        c.tgt_f = ST_P_RD;
      end
      ST_S_INIT: begin
        c.set_found = 1'b1;
        c.kop       = KOP_NM1;
        c.tgt_t     = ST_S_ARD;
      end
      ST_S_ARD: begin
        c.asel  = ASEL_PIVOT;
        c.rd_a  = 1'b1;
        c.tgt_t = ST_S_PV;
      end
      ST_S_PV: begin
        c.ld_pv = 1'b1;
        c.tgt_t = ST_S_RD;
      end
      ST_S_RD: begin
        c.asel  = ASEL_K;
        c.rd_a  = 1'b1;
        c.tgt_t = ST_S_CMP;
      end
      ST_S_CMP: begin
        c.ld_swp = 1'b1;
        c.kop    = KOP_DEC;
        c.flag   = FLG_LT_AP;
        c.tgt_t  = ST_E_INIT;
        c.tgt_f  = ST_S_RD;
      end
      ST_E_INIT: begin
        c.kop   = KOP_CLR;
        c.tgt_t = ST_E_RD;
      end
      ST_E_RD: begin
        c.asel  = ASEL_MAP;
        c.rd_a  = 1'b1;
        c.tgt_t = ST_E_OUT;
      end
      ST_E_OUT: begin
        c.out_valid = 1'b1;
        c.kop       = KOP_INC;
        c.wait_on   = WAIT_OUT;
        c.flag      = FLG_K_END;
        c.tgt_t     = ST_E_DONE;
        c.tgt_f     = ST_E_RD;
      end
      ST_E_DONE: begin
        c.clr_seq = 1'b1;
        c.tgt_t   = ST_IDLE;
      end
      default: begin
        c.tgt_t = ST_IDLE;
        c.tgt_f = ST_IDLE;
      end
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/pp_in_if.sv
`default_nettype none
interface pp_in_if
  import pp_pkg::*;
  ;
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] value;
  logic                    last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/pp_out_if.sv
`default_nettype none
interface pp_out_if
  import pp_pkg::*;
  ;
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] value_res;
  logic                    last_res;
  logic                    no_previous;
  logic                    overflow;

  modport source (output valid, output value_res, output last_res, output no_previous,
                  output overflow, input ready);
  modport sink   (input valid, input value_res, input last_res, input no_previous,
                  input overflow, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/pp_mem.sv
`default_nettype none
module pp_mem
  import pp_pkg::*;
#(
  parameter int DEPTH = MaxLenDefault,
  parameter int AW    = $clog2(MaxLenDefault)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [DataW-1:0] wdata,
  input  logic             re_a,
  input  logic [AW-1:0]    raddr_a,
  input  logic             re_b,
  input  logic [AW-1:0]    raddr_b,
  output logic [DataW-1:0] rdata_a,
  output logic [DataW-1:0] rdata_b
);

  logic [DataW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/pp_seq.sv
`default_nettype none
module pp_seq
  import pp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  stat_t stat,
  output ctrl_t ctl
);

  logic [StepW-1:0] upc;
  logic [StepW-1:0] upc_next;
  ctrl_t            word;
  logic             go;
  logic             flag;

  assign word = ucode(upc);

  always_comb begin
    case (word.wait_on)
      WAIT_IN:  go = stat.in_acc;
      WAIT_OUT: go = stat.out_acc;
      default:  go = 1'b1;
    endcase
  end

  always_comb begin
    case (word.flag)
      FLG_TRUE:  flag = 1'b1;
      FLG_LAST:  flag = stat.last;
      FLG_N_ONE: flag = stat.n_one;
      FLG_LT_AB: flag = stat.lt_ab;
      FLG_K_ONE: flag = stat.k_one;
      FLG_LT_AP: flag = stat.lt_ap;
      FLG_K_END: flag = stat.k_end;
      default:   flag = 1'b1;
    endcase
  end

  // Hold the step and suppress its actions until its handshake completes
  always_comb begin
    ctl = word;
    if (!go) begin
      ctl.kop       = KOP_HOLD;
      ctl.clr_found = 1'b0;
      ctl.set_found = 1'b0;
      ctl.ld_piv    = 1'b0;
      ctl.ld_pv     = 1'b0;
      ctl.ld_swp    = 1'b0;
      ctl.clr_seq   = 1'b0;
    end
    if (go) begin
      upc_next = flag ? word.tgt_t : word.tgt_f;
    end else begin
      upc_next = upc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= ST_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/pp_dpath.sv
`default_nettype none
module pp_dpath
  import pp_pkg::*;
#(
  parameter int MAX_LEN = MaxLenDefault,
  parameter int AW      = $clog2(MaxLenDefault),
  parameter int CW      = $clog2(MaxLenDefault + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  ctrl_t            ctl,
  input  logic             in_acc,
  input  logic             in_last,
  input  logic             out_acc,
  input  logic [DataW-1:0] rdata_a,
  input  logic [DataW-1:0] rdata_b,
  output stat_t            stat,
  output logic             we,
  output logic [AW-1:0]    waddr,
  output logic [AW-1:0]    raddr_a,
  output logic [AW-1:0]    raddr_b,
  output logic             found,
  output logic             ovf
);

  logic [CW-1:0]    count;
  logic [AW-1:0]    k;
  logic [AW-1:0]    pivot;
  logic [AW-1:0]    swp;
  logic [DataW-1:0] pv;
  logic [AW-1:0]    n_m1;
  logic [CW:0]      mirror;
  logic [AW-1:0]    map_addr;
  logic             room;

  assign n_m1  = AW'(count - CW'(1));
  assign room  = count < CW'(MAX_LEN);
  assign we    = in_acc & room;
  assign waddr = count[AW-1:0];

  // Output order after swap and suffix reversal, read in place
  assign mirror = (CW+1)'(count) + (CW+1)'(pivot) - (CW+1)'(k);
  always_comb begin
    if (!found || k < pivot) begin
      map_addr = k;
    end else if (k == pivot) begin
      map_addr = swp;
    end else if (mirror[AW-1:0] == swp) begin
      map_addr = pivot;
    end else begin
      map_addr = mirror[AW-1:0];
    end
  end

  always_comb begin
    case (ctl.asel)
      ASEL_K:     raddr_a = k;
      ASEL_PIVOT: raddr_a = pivot;
      ASEL_MAP:   raddr_a = map_addr;
      default:    raddr_a = k;
    endcase
  end
  assign raddr_b = k - AW'(1);

  assign stat.in_acc  = in_acc;
  assign stat.out_acc = out_acc;
  assign stat.last    = in_last;
  assign stat.n_one   = count == CW'(1);
  assign stat.lt_ab   = $signed(rdata_a) < $signed(rdata_b);
  assign stat.k_one   = k == AW'(1);
  assign stat.lt_ap   = $signed(rdata_a) < $signed(pv);
  assign stat.k_end   = k == n_m1;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (ctl.clr_seq) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (in_acc) begin
      if (room) begin
        count <= count + CW'(1);
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.kop)
      KOP_NM1: k <= n_m1;
      KOP_DEC: k <= k - AW'(1);
      KOP_INC: k <= k + AW'(1);
      KOP_CLR: k <= '0;
      default: k <= k;
    endcase
    if (ctl.clr_found) begin
      found <= 1'b0;
    end else if (ctl.set_found) begin
      found <= 1'b1;
    end
    if (ctl.ld_piv) begin
      pivot <= k - AW'(1);
    end
    if (ctl.ld_pv) begin
      pv <= rdata_a;
    end
    if (ctl.ld_swp) begin
      swp <= k;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/previous_permutation.sv
// Load: items are taken back to back; din is ready whenever the block is idle.
// After the last item: a pivot scan, a swap search, a setup step, the results one at a
// time (each held while dout.ready is low) and a closing step; one control word per step.
// Reset (rst, synchronous) returns the sequencer to idle and clears count and
// overflow; stored elements are not cleared.
`default_nettype none
module previous_permutation
  import pp_pkg::*;
#(
  parameter int MAX_LEN = MaxLenDefault
) (
  input  logic       clk,
  input  logic       rst,
  pp_in_if.sink      din,
  pp_out_if.source   dout
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);

  ctrl_t            ctl;
  stat_t            stat;
  logic             in_acc;
  logic             out_acc;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr_a;
  logic [AW-1:0]    raddr_b;
  logic [DataW-1:0] rdata_a;
  logic [DataW-1:0] rdata_b;
  logic             found;
  logic             ovf;

  // Handshakes: the control word alone decides ready and valid
  assign din.ready  = ctl.in_ready;
  assign dout.valid = ctl.out_valid;
  assign in_acc     = din.valid & din.ready;
  assign out_acc    = dout.valid & dout.ready;

  // Sequencer: step counter over the control store
  pp_seq u_seq (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .ctl  (ctl)
  );

  // Datapath: index counter, pivot, swap point, counts and flags
  pp_dpath #(
    .MAX_LEN (MAX_LEN),
    .AW      (AW),
    .CW      (CW)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .in_acc  (in_acc),
    .in_last (din.last),
    .out_acc (out_acc),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b),
    .stat    (stat),
    .we      (we),
    .waddr   (waddr),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .found   (found),
    .ovf     (ovf)
  );

  // Element store: one write port, two registered read ports
  pp_mem #(
    .DEPTH (MAX_LEN),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (din.value),
    .re_a    (ctl.rd_a),
    .raddr_a (raddr_a),
    .re_b    (ctl.rd_b),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // Result fields: the read register holds while the result waits
  assign dout.value_res   = $signed(rdata_a);
  assign dout.last_res    = stat.k_end;
  assign dout.no_previous = ~found;
  assign dout.overflow    = ovf;

  // Never load while a result is offered
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> !din.ready)
    else $error("input ready while result offered");

  // A final element starts the permutation pass: stop taking items
  a_last_stops_input: assert property (@(posedge clk) disable iff (rst)
    (din.valid && din.ready && din.last) |=> !din.ready)
    else $error("input still taken after last element");

  // After the final result the block returns to loading
  a_back_to_idle: assert property (@(posedge clk) disable iff (rst)
    (dout.valid && dout.ready && dout.last_res) |-> ##2 din.ready)
    else $error("block did not return to idle after final result");

endmodule
`default_nettype wire

// File: dv/previous_permutation_tb.sv
`default_nettype none
module previous_permutation_tb;
  import pp_pkg::*;

  // Store depth of the instance under test; overflow cases run one to eight past it.
  localparam int SeqCap       = MaxLenDefault;
  // Random item budget for the random phase.
  localparam int RandItems    = 180;
  // Hard stop, many times the slowest legal run.
  localparam int CycleLimit   = 600000;
  // Cycles to wait after the last result so a stray extra one is caught.
  localparam int SettleCycles = 16;
  localparam int ValMax       = 32'sh7fff_ffff;
  localparam int ValMin       = 32'sh8000_0000;

  // How the elements of one sequence are chosen.
  typedef enum int {
    FILL_WIDE,
    FILL_NARROW,
    FILL_ASCENDING,
    FILL_DESCENDING,
    FILL_EXTREME
  } fill_t;

  // Receiver back-pressure shapes.
  typedef enum int {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_BURSTY
  } stall_t;

  // One element of the expected previous permutation.
  typedef struct {
    int value;
    bit last;
    bit no_prev;
    bit ovf;
  } perm_elem_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Drive the input channel from local registers so every pin is known at time zero.
  logic        tx_valid = 1'b0;
  logic [31:0] tx_value = '0;
  logic        tx_last  = 1'b0;
  logic        rx_ready = 1'b0;

  pp_in_if  din ();
  pp_out_if dout ();

  assign din.valid  = tx_valid;
  assign din.value  = tx_value;
  assign din.last   = tx_last;
  assign dout.ready = rx_ready;

  previous_permutation #(
    .MAX_LEN(SeqCap)
  ) dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  always #4 clk = ~clk;

  // Shadow of the block's sequence store, filled on each accepted item.
  int         seq_store [SeqCap];
  int         seq_len      = 0;
  bit         seq_ovf      = 1'b0;
  // Elements of previous permutations still owed by the block, oldest first.
  perm_elem_t pending_perm [$];

  int          mismatches  = 0;
  int          cycle_count = 0;
  int          burst_left  = 0;
  stall_t      stall_mode  = RX_OPEN;
  int unsigned stall_left  = 0;
  int unsigned stall_phase = 0;

  task automatic flag_mismatch(input string what);
    $display("mismatch @%0t: %s", $time, what);
    mismatches++;
  endtask

  // Store one accepted item; on the last one, compute the previous
  // permutation of the stored sequence and queue its elements.
  task automatic predict_prev_perm(input int v, input bit is_last);
    int         n, k, piv, swp, lo, hi, tmp;
    bit         found;
    perm_elem_t e;
    if (seq_len < SeqCap) begin
      seq_store[seq_len] = v;
      seq_len++;
    end else begin
      // Drop the item once the store is full, but note the overflow.
      seq_ovf = 1'b1;
    end
    if (!is_last) return;

    n     = seq_len;
    found = 1'b0;
    piv   = 0;
    // Find the rightmost position that has a smaller neighbor right after it.
    for (k = n - 1; k >= 1 && !found; k--) begin
      if (seq_store[k] < seq_store[k-1]) begin
        piv   = k - 1;
        found = 1'b1;
      end
    end

    if (found) begin
      // Swap with the rightmost element after the pivot that is smaller.
      swp = piv + 1;
      for (k = n - 1; k > piv; k--) begin
        if (seq_store[k] < seq_store[piv]) begin
          swp = k;
          break;
        end
      end
      tmp             = seq_store[piv];
      seq_store[piv]  = seq_store[swp];
      seq_store[swp]  = tmp;
      // Reverse the suffix so that it runs descending.
      lo = piv + 1;
      hi = n - 1;
      while (lo < hi) begin
        tmp           = seq_store[lo];
        seq_store[lo] = seq_store[hi];
        seq_store[hi] = tmp;
        lo++;
        hi--;
      end
    end

    for (k = 0; k < n; k++) begin
      e.value   = seq_store[k];
      e.last    = (k == n - 1);
      e.no_prev = !found;
      e.ovf     = seq_ovf;
      pending_perm = {pending_perm, e};
    end
    seq_len = 0;
    seq_ovf = 1'b0;
  endtask

  // Offer one item and hold it until the block takes it. Enter and leave on a
  // falling edge; valid stays high afterwards so back-to-back items never
  // drop it in between.
  task automatic send_item(input int v, input bit is_last);
    if (burst_left == 0) begin
      // Idle for a random gap, then open a new burst.
      tx_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(30, 60);
      else burst_left = $urandom_range(1, 10);
    end
    tx_valid = 1'b1;
    tx_value = v;
    tx_last  = is_last;
    @(posedge clk);
    while (!din.ready) @(posedge clk);
    predict_prev_perm(v, is_last);
    burst_left--;
    @(negedge clk);
  endtask

  // Release the input channel; call on a falling edge.
  task automatic stop_sending();
    tx_valid = 1'b0;
  endtask

  // Hold the sender until every owed element has come out.
  task automatic wait_drained();
    while (pending_perm.size() != 0) @(negedge clk);
  endtask

  // Send one sequence of len items, shaped by fill, last mark on the final one.
  task automatic send_sequence(input int len, input fill_t fill);
    longint cur;
    int     v, k;
    if ($urandom_range(0, 1) == 1) cur = int'($urandom());
    else cur = longint'($urandom_range(0, 16)) - 8;
    for (k = 0; k < len; k++) begin
      case (fill)
        FILL_WIDE: begin
          v = int'($urandom());
        end
        FILL_NARROW: begin
          v = int'($urandom_range(0, 6)) - 3;
        end
        FILL_ASCENDING: begin
          cur = cur + $urandom_range(0, 3);
          if (cur > ValMax) cur = ValMax;
          v = int'(cur);
        end
        FILL_DESCENDING: begin
          cur = cur - $urandom_range(0, 3);
          if (cur < ValMin) cur = ValMin;
          v = int'(cur);
        end
        default: begin
          case ($urandom_range(0, 4))
            0:       v = ValMin;
            1:       v = ValMax;
            2:       v = -1;
            3:       v = 0;
            default: v = 1;
          endcase
        end
      endcase
      send_item(v, k == len - 1);
    end
  endtask

  // Short hand-picked sequences: single elements at both extremes, a plain
  // swap, already-smallest orders, all-equal, signed ordering across zero
  // and across the full range, a three-element case and duplicates in the
  // suffix.
  task automatic test_edge_cases();
    send_item(ValMin, 1'b1);
    send_item(ValMax, 1'b1);
    send_item(5, 1'b0);      send_item(3, 1'b1);
    send_item(1, 1'b0);      send_item(2, 1'b1);
    send_item(7, 1'b0);      send_item(7, 1'b0);      send_item(7, 1'b1);
    send_item(1, 1'b0);      send_item(-1, 1'b1);
    send_item(-1, 1'b0);     send_item(1, 1'b1);
    send_item(ValMax, 1'b0); send_item(ValMin, 1'b1);
    send_item(3, 1'b0);      send_item(1, 1'b0);      send_item(2, 1'b1);
    send_item(4, 1'b0);      send_item(2, 1'b0);      send_item(2, 1'b0);
    send_item(3, 1'b1);
  endtask

  // Fill the store exactly, then overrun it: with the last item itself
  // dropped, with several dropped, and with a sorted prefix so overflow and
  // no-previous show together. A single element after shows overflow clear.
  task automatic test_overflow();
    send_sequence(SeqCap, FILL_WIDE);
    send_sequence(SeqCap + 1, FILL_NARROW);
    send_sequence(SeqCap + 6, FILL_WIDE);
    send_sequence(SeqCap + 3, FILL_ASCENDING);
    send_sequence(1, FILL_WIDE);
  endtask

  // Random sequences, mostly short, some up to full depth, a few overruns.
  // Every ninth sequence the sender holds off until the block has drained.
  task automatic test_random_sequences();
    int sent, seqs, len, pick;
    sent = 0;
    seqs = 0;
    while (sent < RandItems) begin
      pick = $urandom_range(0, 19);
      if (pick <= 12) len = $urandom_range(1, 8);
      else if (pick <= 16) len = $urandom_range(9, 24);
      else if (pick <= 18) len = $urandom_range(25, SeqCap);
      else len = $urandom_range(SeqCap + 1, SeqCap + 8);
      send_sequence(len, fill_t'($urandom_range(0, 4)));
      sent += len;
      seqs++;
      if (seqs % 9 == 0) begin
        stop_sending();
        wait_drained();
      end
    end
  endtask

  // Receiver: pick a new stall shape at random whenever the current stretch runs out;
  // open stretches included so long bursts of results also go through.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 80);
    end
    stall_left--;
    stall_phase++;
    case (stall_mode)
      RX_OPEN:   rx_ready = 1'b1;
      RX_COIN:   rx_ready = 1'($urandom_range(0, 1));
      RX_SPARSE: rx_ready = (stall_phase % 4 == 0);
      default:   rx_ready = (stall_phase % 12 >= 8);
    endcase
  end

  // Compare each accepted element against the oldest owed one.
  always @(posedge clk) begin : check_perm_out
    perm_elem_t e;
    if (!rst && dout.valid && dout.ready) begin
      if (pending_perm.size() == 0) begin
        flag_mismatch($sformatf("unexpected element value=%0d", dout.value_res));
      end else begin
        e = pending_perm.pop_front();
        if (dout.value_res !== e.value)
          flag_mismatch($sformatf("value_res got %0d want %0d", dout.value_res, e.value));
        if (dout.last_res !== e.last)
          flag_mismatch($sformatf("last_res got %b want %b", dout.last_res, e.last));
        if (dout.no_previous !== e.no_prev)
          flag_mismatch($sformatf("no_previous got %b want %b", dout.no_previous, e.no_prev));
        if (dout.overflow !== e.ovf)
          flag_mismatch($sformatf("overflow got %b want %b", dout.overflow, e.ovf));
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    // Hold reset, then release it on a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_edge_cases();
    test_overflow();
    test_random_sequences();

    // Drain, then give the block time to show any extra element.
    stop_sending();
    wait_drained();
    repeat (SettleCycles) @(negedge clk);

    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
hw/rtl/pp_pkg.sv
hw/rtl/pp_in_if.sv
hw/rtl/pp_out_if.sv
hw/rtl/pp_mem.sv
hw/rtl/pp_seq.sv
hw/rtl/pp_dpath.sv
hw/rtl/previous_permutation.sv
dv/previous_permutation_tb.sv
